/* hdl/bpc_pkg.sv */
// Shared types and constants for the button press classifier.
// Used by bpc_core and by the top level; depends on nothing else.
package bpc_pkg;

  // Default width of the internal timestamp arithmetic.
  localparam int unsigned TimeBitsDefault = 32;

  // Width of the configuration index and data fields.
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LEVEL    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_MS     = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_DOUBLE_PRESS_MS = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS_MS   = CfgIdxW'(3);

  // Action that is still waiting to be resolved.
  typedef enum logic [1:0] {
    ACT_SINGLE = 2'd0,
    ACT_DOUBLE = 2'd1,
    ACT_LONG   = 2'd2,
    ACT_NONE   = 2'd3
  } act_e;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic press_event;
    logic release_event;
    logic single_press_event;
    logic double_press_event;
    logic long_press_event;
    logic is_pressed;
  } out_t;

  typedef struct packed {
    logic        active_level;
    logic [15:0] debounce_ms;
    logic [15:0] double_press_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

endpackage

/* hdl/bpc_core.sv */
// Debounce and press classification state with its one-poll update.
// Depends on bpc_pkg for the poll, result, config and action types.
module bpc_core #(
  parameter int unsigned TIME_BITS = bpc_pkg::TimeBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  bpc_pkg::in_t  poll_i,
  input  bpc_pkg::cfg_t cfg_i,
  output bpc_pkg::out_t res_o
);

  logic                 primed_q, primed_d;
  logic                 stable_q, stable_d;
  logic                 prev_q, prev_d;
  logic [TIME_BITS-1:0] bounce_q, bounce_d;
  logic [TIME_BITS-1:0] press_q, press_d;
  logic [TIME_BITS-1:0] release_q, release_d;
  bpc_pkg::act_e        act_q, act_d;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] since_bounce;
  logic [TIME_BITS-1:0] since_release;
  logic [TIME_BITS-1:0] since_press;
  logic [TIME_BITS-1:0] held_time;
  logic                 take_level;

  assign now_t = TIME_BITS'(poll_i.now_ms);

  always_comb begin
    primed_d  = primed_q;
    stable_d  = stable_q;
    prev_d    = prev_q;
    bounce_d  = bounce_q;
    press_d   = press_q;
    release_d = release_q;
    act_d     = act_q;
    res_o     = '0;

    since_bounce  = '0;
    since_release = '0;
    since_press   = '0;
    held_time     = '0;
    take_level    = 1'b0;

    if (!primed_q) begin
      // The first poll only seeds the levels.
      primed_d = 1'b1;
      stable_d = poll_i.pin_level;
      prev_d   = poll_i.pin_level;
    end else begin
      if (poll_i.pin_level != prev_q) begin
        bounce_d = now_t;
      end
      since_bounce = now_t - bounce_d;
      take_level   = (since_bounce >= TIME_BITS'(cfg_i.debounce_ms)) &&
                     (poll_i.pin_level != stable_q);

      if (take_level) begin
        stable_d = poll_i.pin_level;
        if (poll_i.pin_level == cfg_i.active_level) begin
          res_o.press_event = 1'b1;
          press_d = now_t;
          if (act_q == bpc_pkg::ACT_SINGLE) begin
            res_o.double_press_event = 1'b1;
            act_d = bpc_pkg::ACT_DOUBLE;
          end else begin
            act_d = bpc_pkg::ACT_LONG;
          end
        end else begin
          res_o.release_event = 1'b1;
          release_d = now_t;
          held_time = now_t - press_q;
          if (act_q == bpc_pkg::ACT_DOUBLE) begin
            act_d = bpc_pkg::ACT_NONE;
          end else if (held_time < TIME_BITS'(cfg_i.long_press_ms)) begin
            act_d = bpc_pkg::ACT_SINGLE;
          end
        end
      end

      since_release = now_t - release_d;
      if (act_d == bpc_pkg::ACT_SINGLE &&
          since_release > TIME_BITS'(cfg_i.double_press_ms)) begin
        res_o.single_press_event = 1'b1;
        act_d = bpc_pkg::ACT_NONE;
      end

      since_press = now_t - press_d;
      if (act_d == bpc_pkg::ACT_LONG &&
          since_press >= TIME_BITS'(cfg_i.long_press_ms)) begin
        res_o.long_press_event = 1'b1;
        act_d = bpc_pkg::ACT_NONE;
      end

      prev_d = poll_i.pin_level;
    end

    res_o.is_pressed = (stable_d == cfg_i.active_level);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q  <= 1'b0;
      stable_q  <= 1'b0;
      prev_q    <= 1'b0;
      bounce_q  <= '0;
      press_q   <= '0;
      release_q <= '0;
      act_q     <= bpc_pkg::ACT_NONE;
    end else if (step_i) begin
      primed_q  <= primed_d;
      stable_q  <= stable_d;
      prev_q    <= prev_d;
      bounce_q  <= bounce_d;
      press_q   <= press_d;
      release_q <= release_d;
      act_q     <= act_d;
    end
  end

endmodule

/* hdl/button_press_classifier.sv */
// Top level of the debounced button press classifier.
// Depends on bpc_pkg and instantiates bpc_core.
//
// Usage:
//   Each input word is one poll of the button: the raw pin level and a
//   free-running millisecond timestamp. A word is taken on a rising edge
//   where in_valid_i is high and in_stall_o is low. For every poll exactly
//   one result word comes out on the output channel, taken on an edge where
//   out_valid_o is high and out_stall_i is low. The result carries the
//   press, release, single, double and long press flags plus the debounced
//   pressed level.
//   A poll is first captured in an input register, and when it advances the
//   classifier state and the result register are updated together. The
//   block sustains one poll per clock while the receiver does not stall;
//   the only loop is the classifier state.
//   When the receiver stalls, the result register holds its word, the
//   captured poll waits in the input register, and in_stall_o rises once
//   both are occupied. No word is lost or repeated.
//   Reset clears all state; the first poll afterwards only seeds the
//   debounced level and raises no event. Configuration writes are always
//   ready and should be issued only while no poll is in flight.
module button_press_classifier #(
  parameter int unsigned TIME_BITS = bpc_pkg::TimeBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bpc_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bpc_pkg::out_t                out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bpc_pkg::CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  bpc_pkg::cfg_t cfg_q;

  // Input register stage.
  logic          poll_valid_q;
  bpc_pkg::in_t  poll_q;

  // Result register stage.
  logic          res_valid_q;
  bpc_pkg::out_t res_q;
  bpc_pkg::out_t res_d;

  logic          advance;
  logic          in_take;

  // The captured poll moves on when the result register is empty or its
  // word is taken in this same cycle.
  assign advance    = poll_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = poll_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bpc_pkg::CFG_ACTIVE_LEVEL:    cfg_q.active_level    <= cfg_data_i[0];
        bpc_pkg::CFG_DEBOUNCE_MS:     cfg_q.debounce_ms     <= cfg_data_i;
        bpc_pkg::CFG_DOUBLE_PRESS_MS: cfg_q.double_press_ms <= cfg_data_i;
        bpc_pkg::CFG_LONG_PRESS_MS:   cfg_q.long_press_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: loads whenever a new word is accepted, otherwise it
  // empties when its poll advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_valid_q <= 1'b0;
    end else if (in_take) begin
      poll_valid_q <= 1'b1;
    end else if (advance) begin
      poll_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      poll_q <= in_data_i;
    end
  end

  bpc_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .poll_i (poll_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  // A poll cannot both press and release.
  a_press_xor_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.press_event && out_data_o.release_event))
    else $error("press and release in one result word");

  // Single, double and long resolve different pending actions.
  a_one_class : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_data_o.single_press_event,
                              out_data_o.double_press_event,
                              out_data_o.long_press_event}))
    else $error("more than one press class in one result word");

  // Edges agree with the reported debounced level.
  a_edge_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.press_event || out_data_o.release_event)) |->
      (out_data_o.is_pressed == out_data_o.press_event))
    else $error("edge event disagrees with is_pressed");

  // The input side only stalls with a poll waiting in the input register.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (poll_valid_q && res_valid_q && out_stall_i))
    else $error("input stalled without a blocked poll");

endmodule

/* bench/button_press_classifier_tb.sv */
// Self-checking testbench for the debounced button press classifier.
// Depends on bpc_pkg and button_press_classifier from the hdl folder; reads no files.
`timescale 1ns / 100ps

module button_press_classifier_tb;

  // The run is cut off here if the block stops moving words.
  localparam int unsigned CycleLimit = 400000;
  // Cycles to let pass after the last expected word before touching registers.
  localparam int unsigned SettleCycles = 4;
  // An index that maps to no register; writes to it must be ignored.
  localparam logic [bpc_pkg::CfgIdxW-1:0] CFG_UNMAPPED = bpc_pkg::CfgIdxW'(8'hFF);

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  bpc_pkg::in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bpc_pkg::out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [bpc_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [bpc_pkg::CfgDataW-1:0] cfg_data_i;

  always #5 clk_i = ~clk_i;

  button_press_classifier u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Our own copy of the classifier: configuration and state, updated once per
  // accepted poll word, in the same order as the block is meant to do it.
  bpc_pkg::cfg_t model_cfg;
  logic seeded;
  logic held_level;
  logic last_raw;
  logic [31:0] settle_ms;
  logic [31:0] down_ms;
  logic [31:0] up_ms;
  bpc_pkg::act_e waiting;

  // Result words predicted but not yet seen on the output channel.
  bpc_pkg::out_t expected_q[$];

  int unsigned polls_sent;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  // Words taken by the checker, and how many of them the receiver has paced.
  int unsigned words_taken = 0;
  int unsigned words_paced = 0;
  int unsigned hold_cycles = 0;
  // When set, neither side idles; used to get bursts of back-to-back words.
  logic quiet;
  // Running timestamp that the gesture generator advances.
  logic [31:0] clock_ms;

  // Computes the result word of one poll and advances the predicted state.
  // Within a poll the debounce and edge handling comes first, then the
  // single press timeout, then the long press check.
  function automatic bpc_pkg::out_t classify_poll(bpc_pkg::in_t word);
    bpc_pkg::out_t res;
    logic [31:0] since_bounce;
    logic [31:0] held_for;
    res = '0;
    if (!seeded) begin
      // The first poll after reset only seeds the levels.
      seeded = 1'b1;
      held_level = word.pin_level;
      last_raw = word.pin_level;
    end else begin
      if (word.pin_level != last_raw) begin
        settle_ms = word.now_ms;
      end
      since_bounce = word.now_ms - settle_ms;
      if (since_bounce >= 32'(model_cfg.debounce_ms) && word.pin_level != held_level) begin
        held_level = word.pin_level;
        if (held_level == model_cfg.active_level) begin
          res.press_event = 1'b1;
          down_ms = word.now_ms;
          if (waiting == bpc_pkg::ACT_SINGLE) begin
            res.double_press_event = 1'b1;
            waiting = bpc_pkg::ACT_DOUBLE;
          end else begin
            waiting = bpc_pkg::ACT_LONG;
          end
        end else begin
          res.release_event = 1'b1;
          up_ms = word.now_ms;
          held_for = up_ms - down_ms;
          // Releasing the second press of a double ends the gesture.
          if (waiting == bpc_pkg::ACT_DOUBLE) begin
            waiting = bpc_pkg::ACT_NONE;
          end else if (held_for < 32'(model_cfg.long_press_ms)) begin
            waiting = bpc_pkg::ACT_SINGLE;
          end
        end
      end
      if (waiting == bpc_pkg::ACT_SINGLE &&
          (word.now_ms - up_ms) > 32'(model_cfg.double_press_ms)) begin
        res.single_press_event = 1'b1;
        waiting = bpc_pkg::ACT_NONE;
      end
      if (waiting == bpc_pkg::ACT_LONG &&
          (word.now_ms - down_ms) >= 32'(model_cfg.long_press_ms)) begin
        res.long_press_event = 1'b1;
        waiting = bpc_pkg::ACT_NONE;
      end
      last_raw = word.pin_level;
    end
    res.is_pressed = (held_level == model_cfg.active_level);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_flag(input string name, input logic got, input logic want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %b expected %b", name, got, want));
    end
  endtask

  // Result checker: every word taken from the output channel is compared with
  // the oldest prediction.
  always @(posedge clk_i) begin : check_results
    bpc_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_q.pop_front();
        check_flag("press_event", out_data_o.press_event, want.press_event);
        check_flag("release_event", out_data_o.release_event, want.release_event);
        check_flag("single_press_event", out_data_o.single_press_event,
                   want.single_press_event);
        check_flag("double_press_event", out_data_o.double_press_event,
                   want.double_press_event);
        check_flag("long_press_event", out_data_o.long_press_event, want.long_press_event);
        check_flag("is_pressed", out_data_o.is_pressed, want.is_pressed);
      end
      words_taken++;
    end
  end

  // The receiver stall counts down on falling edges so that it never changes
  // at the edge where the output is sampled. After each taken word it draws
  // how long to hold off the next one.
  always @(negedge clk_i) begin
    if (words_taken != words_paced) begin
      words_paced = words_taken;
      hold_cycles = quiet ? 0 : $urandom_range(0, 3);
    end
    if (hold_cycles != 0) begin
      out_stall_i = 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sends one poll word after a random gap and records its prediction once the
  // block has taken it. Valid stays high after acceptance; the next call either
  // replaces the word or lowers valid at the following falling edge.
  task automatic send_poll(input logic pin, input logic [31:0] stamp);
    int unsigned gap;
    bpc_pkg::in_t word;
    gap = quiet ? 0 : $urandom_range(0, 3);
    word.pin_level = pin;
    word.now_ms = stamp;
    clock_ms = stamp;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(classify_poll(word));
    polls_sent++;
  endtask

  // Lowers valid, waits for every predicted word, then lets the pipeline drain.
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register write; the block must be idle when this is called.
  task automatic write_reg(input logic [bpc_pkg::CfgIdxW-1:0] idx,
                           input logic [bpc_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      bpc_pkg::CFG_ACTIVE_LEVEL:    model_cfg.active_level = data[0];
      bpc_pkg::CFG_DEBOUNCE_MS:     model_cfg.debounce_ms = data;
      bpc_pkg::CFG_DOUBLE_PRESS_MS: model_cfg.double_press_ms = data;
      bpc_pkg::CFG_LONG_PRESS_MS:   model_cfg.long_press_ms = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(input logic active, input logic [15:0] debounce,
                            input logic [15:0] double_win, input logic [15:0] long_hold);
    wait_quiet();
    write_reg(bpc_pkg::CFG_ACTIVE_LEVEL, bpc_pkg::CfgDataW'(active));
    write_reg(bpc_pkg::CFG_DEBOUNCE_MS, debounce);
    write_reg(bpc_pkg::CFG_DOUBLE_PRESS_MS, double_win);
    write_reg(bpc_pkg::CFG_LONG_PRESS_MS, long_hold);
  endtask

  // Draws a register setting: mostly moderate, sometimes zero or all ones.
  function automatic logic [15:0] pick_setting(input int unsigned typical);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, typical));
    endcase
  endfunction

  // Holds one level for about dur milliseconds, preceded by some contact
  // bounce that is shorter than the debounce time.
  task automatic hold_level(input logic lvl, input int unsigned dur);
    int unsigned polls;
    int unsigned bounce_max;
    bounce_max = model_cfg.debounce_ms / 2;
    repeat ($urandom_range(0, 2)) begin
      send_poll(~lvl, clock_ms + $urandom_range(0, bounce_max));
      send_poll(lvl, clock_ms + $urandom_range(0, bounce_max));
    end
    polls = $urandom_range(1, 4);
    repeat (polls) send_poll(lvl, clock_ms + $urandom_range(1, 2 * dur / polls + 1));
  endtask

  // With all registers at zero: the seeding poll at the top of the time range,
  // then a press that is accepted at once and is long at once, and a release
  // that schedules no single press.
  task automatic test_seed_and_zero_times();
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'h0000_0000);
    send_poll(1'b1, 32'h0000_0001);
    send_poll(1'b1, 32'h8000_0000);
  endtask

  // Active high, no debounce: single, double and long presses, and the
  // release of a double press that ends the gesture.
  task automatic test_press_classes();
    set_config(1'b1, 16'd0, 16'd10, 16'd20);
    send_poll(1'b0, 32'd100);
    send_poll(1'b1, 32'd110);
    send_poll(1'b0, 32'd115);
    send_poll(1'b0, 32'd126);
    send_poll(1'b1, 32'd130);
    send_poll(1'b0, 32'd132);
    send_poll(1'b1, 32'd135);
    send_poll(1'b0, 32'd137);
    send_poll(1'b1, 32'd140);
    send_poll(1'b1, 32'd160);
    send_poll(1'b0, 32'd170);
  endtask

  // Bounce shorter than the debounce time, a timestamp that goes backwards,
  // and a release whose settle time spans the wrap of the counter.
  task automatic test_debounce_and_wrap();
    set_config(1'b1, 16'd8, 16'd10, 16'd20);
    send_poll(1'b1, 32'd200);
    send_poll(1'b0, 32'd203);
    send_poll(1'b1, 32'd205);
    send_poll(1'b1, 32'd213);
    send_poll(1'b1, 32'd100);
    send_poll(1'b0, 32'hFFFF_FFF0);
    send_poll(1'b0, 32'h0000_0004);
  endtask

  // A write to an unmapped index is dropped, and only bit 0 of the data
  // reaches the active level register.
  task automatic test_config_edges();
    wait_quiet();
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    write_reg(bpc_pkg::CFG_ACTIVE_LEVEL, 16'hFFFE);
    send_poll(1'b0, 32'd1000);
    send_poll(1'b1, 32'd1100);
  endtask

  // Random gestures under a series of settings. Most traffic is press and
  // release pairs with bounce and random timing scaled to the settings; the
  // rest is lone polls at random times, which also makes the timestamp jump.
  task automatic test_random_gestures();
    int unsigned phase_target;
    int unsigned deb;
    int unsigned dbl;
    int unsigned lng;
    logic pressed_pin;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        set_config(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      end else begin
        set_config(1'($urandom_range(0, 1)), pick_setting(12), pick_setting(60),
                   pick_setting(250));
      end
      deb = model_cfg.debounce_ms;
      dbl = model_cfg.double_press_ms;
      lng = model_cfg.long_press_ms;
      // Odd phases start just below the wrap of the timestamp.
      clock_ms = (phase % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 300000) : $urandom();
      phase_target = polls_sent + 62;
      while (polls_sent < phase_target) begin
        quiet = ($urandom_range(0, 5) == 0);
        pressed_pin = model_cfg.active_level;
        if ($urandom_range(0, 7) == 0) begin
          send_poll(1'($urandom_range(0, 1)), $urandom());
        end else begin
          hold_level(pressed_pin, $urandom_range(0, 2 * (deb + lng) + 4));
          hold_level(~pressed_pin, $urandom_range(0, 2 * (deb + dbl) + 4));
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    model_cfg = '0;
    seeded = 1'b0;
    held_level = 1'b0;
    last_raw = 1'b0;
    settle_ms = '0;
    down_ms = '0;
    up_ms = '0;
    waiting = bpc_pkg::ACT_NONE;
    polls_sent = 0;
    quiet = 1'b0;
    clock_ms = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_seed_and_zero_times();
    test_press_classes();
    test_debounce_and_wrap();
    test_config_edges();
    test_random_gestures();

    wait_quiet();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/bpc_pkg.sv
hdl/bpc_core.sv
hdl/button_press_classifier.sv
bench/button_press_classifier_tb.sv
